// ----- hdl/sparse_triplet_table_core_assert.svh -----
// Assertion macros for the sparse triplet table core.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SPARSE_TRIPLET_TABLE_CORE_ASSERT_SVH
`define SPARSE_TRIPLET_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/stt_pkg.sv -----
// Shared types and constants of the sparse triplet table core.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package stt_pkg;

    // Default sizes of the table and of the matrix.
    localparam int DEF_CAPACITY = 128;
    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    // Field widths fixed by the interface.
    localparam int COORD_W   = 4;
    localparam int VAL_W     = 32;
    localparam int TOTAL_W   = 8;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int ENTRY_W   = 2 * COORD_W + VAL_W;
    localparam int IN_DATA_W = 2 * COORD_W + VAL_W;
    localparam int OUT_DATA_W = VAL_W + TOTAL_W;

    // Operation codes carried with each request.
    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_LOAD  = 2'd3
    } t_op;

    // Outcome codes returned with each result.
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT       = 3'd0,
        ST_APPENDED  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_ZERO      = 3'd4
    } t_status;

    // Change applied to the table when a request completes.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_UPDATE,
        ACT_APPEND
    } t_act;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    scan_init;
        logic    scan_step;
        logic    commit;
        t_act    act;
        t_status st;
        logic    ret_val;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic in_range;
        logic nonzero;
        logic found;
        logic scan_done;
        logic full;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- hdl/stt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; no package needed.
`default_nettype none

module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read in the same clock.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/stt_ctrl.sv -----
// Controller of the sparse triplet table: sequences accept, decode, scan and commit.
// Depends on stt_pkg for the command and status structs and the codes.
`default_nettype none

module stt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire stt_pkg::t_dp_sts i_sts,
    output stt_pkg::t_dp_cmd      o_cmd
);

    import stt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_s_tready;
    logic    n_s_tready;
    t_dp_cmd w_cmd;

    // Next state and the commands for the datapath.
    always_comb begin
        n_state       = r_state;
        w_cmd.capture   = 1'b0;
        w_cmd.scan_init = 1'b0;
        w_cmd.scan_step = 1'b0;
        w_cmd.commit    = 1'b0;
        w_cmd.act       = ACT_NONE;
        w_cmd.st        = ST_HIT;
        w_cmd.ret_val   = 1'b0;

        // Outcome of the request, as settled by the scan and the fill level.
        if (i_sts.op == OP_CLEAR) begin
            w_cmd.act = ACT_CLEAR;
            w_cmd.st  = ST_HIT;
        end else if (!i_sts.in_range) begin
            w_cmd.st = ST_NOT_FOUND;
        end else begin
            case (i_sts.op)
                OP_READ: begin
                    w_cmd.st      = i_sts.found ? ST_HIT : ST_NOT_FOUND;
                    w_cmd.ret_val = i_sts.found;
                end
                OP_WRITE: begin
                    if (i_sts.found) begin
                        w_cmd.act = ACT_UPDATE;
                        w_cmd.st  = ST_HIT;
                    end else if (i_sts.full) begin
                        w_cmd.st = ST_FULL;
                    end else begin
                        w_cmd.act = ACT_APPEND;
                        w_cmd.st  = ST_APPENDED;
                    end
                end
                default: begin
                    if (!i_sts.nonzero) begin
                        w_cmd.st = ST_ZERO;
                    end else if (i_sts.full) begin
                        w_cmd.st = ST_FULL;
                    end else begin
                        w_cmd.act = ACT_APPEND;
                        w_cmd.st  = ST_APPENDED;
                    end
                end
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                w_cmd.capture = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                // Only in-range reads and writes need to look through the table.
                if (i_sts.op == OP_CLEAR || i_sts.op == OP_LOAD || !i_sts.in_range) begin
                    n_state = S_COMMIT;
                end else begin
                    w_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                w_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // Wait here while the previous result is still held.
                if (i_sts.out_free) begin
                    w_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_s_tready = (n_state == S_IDLE);
    end

    // State register and registered ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_s_tready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_s_tready <= n_s_tready;
        end
    end

    assign o_s_tready = r_s_tready;
    assign o_cmd      = w_cmd;

endmodule

`default_nettype wire

// ----- hdl/stt_dp.sv -----
// Datapath of the sparse triplet table: request register, triplet memory,
// pipelined scan, fill count and output register. Depends on stt_pkg and stt_ram.
`default_nettype none

module stt_dp #(
    parameter int CAPACITY = stt_pkg::DEF_CAPACITY,
    parameter int MAX_ROWS = stt_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = stt_pkg::DEF_MAX_COLS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [stt_pkg::OP_W-1:0]        i_op,
    input  wire logic [stt_pkg::COORD_W-1:0]     i_row,
    input  wire logic [stt_pkg::COORD_W-1:0]     i_col,
    input  wire logic [stt_pkg::VAL_W-1:0]       i_val,
    input  wire stt_pkg::t_dp_cmd                i_cmd,
    output stt_pkg::t_dp_sts                     o_sts,
    input  wire logic                            i_m_tready,
    output logic                                 o_m_tvalid,
    output logic      [stt_pkg::VAL_W-1:0]       o_read_value,
    output logic      [stt_pkg::STATUS_W-1:0]    o_status,
    output logic      [stt_pkg::TOTAL_W-1:0]     o_entry_total
);

    import stt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Latched request.
    t_op                r_op;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_col;
    logic [VAL_W-1:0]   r_val;

    // Table fill level and scan state.
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      r_addr;
    logic [AW-1:0]      r_cmp_addr;
    logic               r_pend;
    logic               r_found;
    logic [AW-1:0]      r_hit_addr;
    logic [VAL_W-1:0]   r_hit_val;

    // Output register.
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_rv;
    logic [STATUS_W-1:0] r_out_st;
    logic [TOTAL_W-1:0] r_out_total;

    logic               w_in_range;
    logic               w_full;
    logic               w_is_write;
    logic               w_issue;
    logic               w_match;
    logic               w_out_free;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [ENTRY_W-1:0] w_rdata;
    logic [COORD_W-1:0] w_rd_row;
    logic [COORD_W-1:0] w_rd_col;
    logic [VAL_W-1:0]   w_rd_val;

    // Triplet memory: row and column above the value.
    stt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_addr[AW-1:0]),
        .o_rdata(w_rdata)
    );

    assign w_rd_val = w_rdata[VAL_W-1:0];
    assign w_rd_col = w_rdata[VAL_W +: COORD_W];
    assign w_rd_row = w_rdata[VAL_W + COORD_W +: COORD_W];

    // Request decode.
    assign w_in_range = (32'(r_row) < MAX_ROWS) && (32'(r_col) < MAX_COLS);
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_is_write = (r_op == OP_WRITE);
    assign w_out_free = !r_out_valid || i_m_tready;

    // A write stops issuing reads once its first match is known.
    assign w_issue = (r_addr < r_count) && !(w_is_write && r_found);
    assign w_match = r_pend && (w_rd_row == r_row) && (w_rd_col == r_col);

    // Memory write for an update or an append.
    assign w_we    = i_cmd.commit && (i_cmd.act == ACT_UPDATE || i_cmd.act == ACT_APPEND);
    assign w_waddr = (i_cmd.act == ACT_UPDATE) ? r_hit_addr : r_count[AW-1:0];
    assign w_wdata = {r_row, r_col, r_val};

    // Fill level after the request completes.
    always_comb begin
        case (i_cmd.act)
            ACT_CLEAR:  n_count = '0;
            ACT_APPEND: n_count = r_count + CW'(1);
            default:    n_count = r_count;
        endcase
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_op);
            r_row <= i_row;
            r_col <= i_col;
            r_val <= i_val;
        end
    end

    // Scan pipeline: issue one address a cycle, compare the entry read back in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_addr  <= '0;
        end else if (i_cmd.scan_init) begin
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_addr  <= '0;
        end else if (i_cmd.scan_step) begin
            r_pend     <= w_issue;
            r_cmp_addr <= r_addr[AW-1:0];
            if (w_issue) begin
                r_addr <= r_addr + CW'(1);
            end
            // A read keeps the last match, a write the first.
            if (w_match && !(w_is_write && r_found)) begin
                r_found    <= 1'b1;
                r_hit_addr <= r_cmp_addr;
                r_hit_val  <= w_rd_val;
            end
        end
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    // Output register, loaded on commit and freed when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_rv    <= i_cmd.ret_val ? r_hit_val : '0;
            r_out_st    <= i_cmd.st;
            r_out_total <= TOTAL_W'(n_count);
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.in_range  = w_in_range;
    assign o_sts.nonzero   = (r_val != '0);
    assign o_sts.found     = r_found;
    assign o_sts.scan_done = !r_pend && ((r_addr >= r_count) || (w_is_write && r_found));
    assign o_sts.full      = w_full;
    assign o_sts.out_free  = w_out_free;

    assign o_m_tvalid    = r_out_valid;
    assign o_read_value  = r_out_rv;
    assign o_status      = r_out_st;
    assign o_entry_total = r_out_total;

endmodule

`default_nettype wire

// ----- hdl/sparse_triplet_table_core.sv -----
// Top level of the sparse triplet table core: controller plus datapath.
// Depends on stt_pkg, stt_ctrl, stt_dp, stt_ram and the assertion macro header.
//
//  Channel  Dir  Handshake            Contents
//  s        in   i_s_tvalid/o_s_tready  tuser: op; tdata: row, col, value
//  m        out  o_m_tvalid/i_m_tready  tuser: status; tdata: read value, total
//
// A clear, a dense load or an out-of-range request goes from decode straight to
// commit. A read or a write scans the table, up to CAPACITY entries: the stored
// triplets are scanned one a cycle through the single read port of the triplet
// memory. A write stops scanning one entry after its first match. One request
// is in work at a time; a finished result waits in the output register while
// the next request is accepted, and a completion is held back only while that
// register is still full. Reset empties the table.
`default_nettype none

module sparse_triplet_table_core #(
    parameter int CAPACITY = stt_pkg::DEF_CAPACITY,
    parameter int MAX_ROWS = stt_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = stt_pkg::DEF_MAX_COLS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // [1:0] op
    input  wire logic [stt_pkg::OP_W-1:0]          i_s_tuser,
    // [3:0] row_index, [7:4] col_index, [39:8] elem_value
    input  wire logic [stt_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // [2:0] status
    output logic      [stt_pkg::STATUS_W-1:0]      o_m_tuser,
    // [31:0] read_value, [39:32] entry_total
    output logic      [stt_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    import stt_pkg::*;

    t_dp_cmd             w_cmd;
    t_dp_sts             w_sts;
    logic [VAL_W-1:0]    w_read_value;
    logic [TOTAL_W-1:0]  w_entry_total;
    logic                w_commit_append;
    logic                w_commit_clear;
    logic                w_total_zero;

    // Request sequencing.
    stt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // Table storage, scan and result.
    stt_dp #(
        .CAPACITY(CAPACITY),
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (i_s_tuser),
        .i_row        (i_s_tdata[COORD_W-1:0]),
        .i_col        (i_s_tdata[2*COORD_W-1:COORD_W]),
        .i_val        (i_s_tdata[IN_DATA_W-1:2*COORD_W]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_read_value (w_read_value),
        .o_status     (o_m_tuser),
        .o_entry_total(w_entry_total)
    );

    assign o_m_tdata = {w_entry_total, w_read_value};

    // Shorthands for the checks below.
    assign w_commit_append = w_cmd.commit && (w_cmd.act == ACT_APPEND);
    assign w_commit_clear  = w_cmd.commit && (w_cmd.act == ACT_CLEAR);
    assign w_total_zero    = (w_entry_total == '0);

    // Checks on the controller and datapath working together.
    `include "sparse_triplet_table_core_assert.svh"

    `STT_ASSERT_SAME(a_commit_needs_free, w_cmd.commit, w_sts.out_free, "commit while result held")
    `STT_ASSERT_SAME(a_no_commit_when_ready, o_s_tready, !w_cmd.commit, "commit while idle")
    `STT_ASSERT_SAME(a_no_append_full, w_commit_append, !w_sts.full, "append into full table")
    `STT_ASSERT_NEXT(a_clear_empties, w_commit_clear, o_m_tvalid && w_total_zero, "clear left entries")

endmodule

`default_nettype wire
